/* rtl/core/ice_pkg.sv */
// ----------------------------------------------------------------------------
// ice_pkg - shared types and helpers for the Internet checksum engine
// Holds the queue entry passed from front to back, queue depth defaults and
// the 16-bit end-around-carry add.
// ----------------------------------------------------------------------------
package ice_pkg;

  localparam int unsigned CmdDepthDef = 4;
  localparam int unsigned ResDepthDef = 2;

  localparam logic [15:0] SumMask = 16'hFFFF;

  // One classified word: partial sum already folded to 16 bits
  typedef struct packed {
    logic [15:0] part_sum;
    logic        first;
    logic        last;
  } cmd_t;

  // Ones'-complement add with end-around carry; never carries twice
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

/* rtl/core/ice_front.sv */
// ----------------------------------------------------------------------------
// ice_front - word classifier and command queue
// Masks an odd tail byte, adds the pseudoheader on a first word, folds the
// partial sum to 16 bits and queues it for the accumulator.
// ----------------------------------------------------------------------------
module ice_front import ice_pkg::*; #(
  parameter int unsigned CmdDepth = CmdDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [15:0] data_word_i,
  input  logic        odd_tail_i,
  input  logic        first_word_i,
  input  logic        last_word_i,
  input  logic        with_pseudo_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] destination_address_i,
  input  logic [7:0]  protocol_i,
  input  logic [15:0] segment_length_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  localparam int unsigned PtrW = $clog2(CmdDepth);
  localparam int unsigned CntW = $clog2(CmdDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CmdDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CmdDepth);

  logic [15:0]     word_m;
  logic            add_ph;
  logic [18:0]     raw_sum;
  logic [16:0]     fold1;
  logic [15:0]     fold2;
  cmd_t            entry;

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push_fire, pop_fire;

  // Classify: tail mask, pseudoheader terms, two-step fold
  always_comb begin
    word_m  = odd_tail_i ? {data_word_i[15:8], 8'h00} : data_word_i;
    add_ph  = first_word_i & with_pseudo_i;
    raw_sum = {3'd0, word_m};
    if (add_ph) begin
      raw_sum = raw_sum
              + {3'd0, source_address_i[31:16]} + {3'd0, source_address_i[15:0]}
              + {3'd0, destination_address_i[31:16]}
              + {3'd0, destination_address_i[15:0]}
              + {11'd0, protocol_i} + {3'd0, segment_length_i};
    end
    fold1 = {1'b0, raw_sum[15:0]} + {14'd0, raw_sum[18:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
    entry.part_sum = fold2 & SumMask;
    entry.first    = first_word_i;
    entry.last     = last_word_i;
  end

  // Queue control
  assign full_o      = (cnt_q == FullCnt);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign push_fire   = push_i & ~full_o;
  assign pop_fire    = cmd_valid_o & cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_fire && pop_fire) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("command queue count overflow");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fire && !pop_fire |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("command queue lost a beat");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o && !cmd_ready_i |=> cmd_valid_o && $stable(cmd_o))
    else $error("stalled command changed");

endmodule

/* rtl/core/ice_back.sv */
// ----------------------------------------------------------------------------
// ice_back - running sum accumulator and result queue
// Adds each queued partial sum into the running sum with end-around carry
// and queues the complemented sum on a last word.
// ----------------------------------------------------------------------------
module ice_back import ice_pkg::*; #(
  parameter int unsigned ResDepth = ResDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] checksum_o
);

  localparam int unsigned PtrW = $clog2(ResDepth);
  localparam int unsigned CntW = $clog2(ResDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(ResDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(ResDepth);

  logic [15:0]     sum_q, sum_d;
  logic [15:0]     base;
  logic            cmd_fire, res_push, res_pop, res_full;

  logic [15:0]     res_mem_q [ResDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Handshake: a last word needs room in the result queue
  assign res_full    = (cnt_q == FullCnt);
  assign empty_o     = (cnt_q == '0);
  assign res_pop     = pop_i & ~empty_o;
  assign cmd_ready_o = ~cmd_i.last | ~res_full | pop_i;
  assign cmd_fire    = cmd_valid_i & cmd_ready_o;
  assign res_push    = cmd_fire & cmd_i.last;
  assign checksum_o  = res_mem_q[rd_ptr_q];

  // Accumulate
  assign base  = cmd_i.first ? 16'd0 : sum_q;
  assign sum_d = cmd_fire ? ones_add(base, cmd_i.part_sum) : sum_q;

  // Result queue control
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (res_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (res_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (res_push && !res_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!res_push && res_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      sum_q    <= sum_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Result storage, no reset
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[wr_ptr_q] <= ~sum_d;
    end
  end

  // Checks
  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("result queue overflow");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire && !cmd_i.last && !res_pop |=> cnt_q == $past(cnt_q))
    else $error("result queued for a non-last word");
  a_first_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire && cmd_i.first |=> sum_q == $past(cmd_i.part_sum))
    else $error("first word did not restart the sum");

endmodule

/* rtl/core/internet_checksum_engine_top.sv */
// ----------------------------------------------------------------------------
// internet_checksum_engine_top - RFC 1071 checksum with optional pseudoheader
//
//   channel  | handshake      | beat
//   ---------+----------------+---------------------------------------------
//   input    | push_i, full_o | data word, flags, pseudoheader fields
//   result   | pop_i, empty_o | checksum_o
//
// One word per cycle sustained while full_o stays low. A word is written into
// the command queue and is added into the running sum when the back part takes
// it; on a last word the complemented sum enters the result queue on that same
// edge. The single 16-bit end-around-carry add in the back part sets the rate.
// Reset clears the running sum and both queues. Result stalls back up through
// the result queue (ResDepth) and the command queue (CmdDepth) before full_o.
// ----------------------------------------------------------------------------
module internet_checksum_engine_top import ice_pkg::*; #(
  parameter int unsigned CmdDepth = CmdDepthDef,
  parameter int unsigned ResDepth = ResDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [15:0] data_word_i,
  input  logic        odd_tail_i,
  input  logic        first_word_i,
  input  logic        last_word_i,
  input  logic        with_pseudo_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] destination_address_i,
  input  logic [7:0]  protocol_i,
  input  logic [15:0] segment_length_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] checksum_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Front: classify and queue
  ice_front #(
    .CmdDepth(CmdDepth)
  ) u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push_i               (push_i),
    .full_o               (full_o),
    .data_word_i          (data_word_i),
    .odd_tail_i           (odd_tail_i),
    .first_word_i         (first_word_i),
    .last_word_i          (last_word_i),
    .with_pseudo_i        (with_pseudo_i),
    .source_address_i     (source_address_i),
    .destination_address_i(destination_address_i),
    .protocol_i           (protocol_i),
    .segment_length_i     (segment_length_i),
    .cmd_valid_o          (cmd_valid),
    .cmd_ready_i          (cmd_ready),
    .cmd_o                (cmd)
  );

  // Back: accumulate and deliver
  ice_back #(
    .ResDepth(ResDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .checksum_o (checksum_o)
  );

endmodule

/* dv/internet_checksum_engine_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// internet_checksum_engine_checker - checksum predictor and result compare
// Watches the word channel and the checksum channel of the engine. Every
// accepted word updates a private running sum; a last word queues the
// expected checksum, and each popped checksum is matched against the oldest.
// ----------------------------------------------------------------------------
module internet_checksum_engine_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [15:0] data_word_i,
  input  logic        odd_tail_i,
  input  logic        first_word_i,
  input  logic        last_word_i,
  input  logic        with_pseudo_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] destination_address_i,
  input  logic [7:0]  protocol_i,
  input  logic [15:0] segment_length_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [15:0] checksum_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [15:0] sum_model;
  logic [15:0] expected_sums[$];
  int unsigned mismatches;

  // Fold a wide sum until no carry is left above bit 15
  function automatic logic [15:0] fold_sum(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    while (v[31:16] != 16'd0) begin
      v = {16'd0, v[15:0]} + {16'd0, v[31:16]};
    end
    return v[15:0];
  endfunction

  // Compare popped checksums first, then fold in the accepted word
  always @(posedge clk_i or negedge rst_ni) begin : track_p
    logic [31:0] acc;
    logic [15:0] word;
    logic [15:0] want;
    if (!rst_ni) begin
      sum_model = '0;
      expected_sums.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_sums.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t checksum beat 0x%04h with nothing expected", $realtime, checksum_i);
          end
        end else begin
          want = expected_sums.pop_front();
          if (checksum_i !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t checksum mismatch: expected 0x%04h, got 0x%04h",
                       $realtime, want, checksum_i);
            end
          end
        end
      end
      if (push_i && !full_i) begin
        acc = first_word_i ? 32'd0 : {16'd0, sum_model};
        // pseudoheader only counts on a first word
        if (first_word_i && with_pseudo_i) begin
          acc += {16'd0, source_address_i[31:16]};
          acc += {16'd0, source_address_i[15:0]};
          acc += {16'd0, destination_address_i[31:16]};
          acc += {16'd0, destination_address_i[15:0]};
          acc += {24'd0, protocol_i};
          acc += {16'd0, segment_length_i};
        end
        word = odd_tail_i ? {data_word_i[15:8], 8'h00} : data_word_i;
        acc += {16'd0, word};
        sum_model = fold_sum(acc);
        if (last_word_i) begin
          expected_sums.push_back(~sum_model);
        end
      end
    end
    pending_o    <= expected_sums.size();
    fail_count_o <= mismatches;
  end

endmodule

/* dv/internet_checksum_engine_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// internet_checksum_engine_top_tb - stimulus and verdict for the checksum engine
// Drives directed corner words and then random packets, with and without the
// pseudoheader, plus stray words. Both channels stall in random bursts; the
// checker beside the engine predicts and compares every checksum beat.
// ----------------------------------------------------------------------------
module internet_checksum_engine_top_tb;

  localparam int unsigned WordTarget = 1650;
  localparam int unsigned QuietFrom  = 1450;
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] data_word = '0;
  logic        odd_tail = 1'b0;
  logic        first_word = 1'b0;
  logic        last_word = 1'b0;
  logic        with_pseudo = 1'b0;
  logic [31:0] source_address = '0;
  logic [31:0] destination_address = '0;
  logic [7:0]  protocol = '0;
  logic [15:0] segment_length = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] checksum;

  bit          quiet_tail = 1'b0;
  int unsigned pop_stall = 0;
  int unsigned words_sent = 0;
  int unsigned fail_count;
  int unsigned pending;

  always #2 clk_i = ~clk_i;

  internet_checksum_engine_top dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_n),
    .push_i                (push),
    .full_o                (full),
    .data_word_i           (data_word),
    .odd_tail_i            (odd_tail),
    .first_word_i          (first_word),
    .last_word_i           (last_word),
    .with_pseudo_i         (with_pseudo),
    .source_address_i      (source_address),
    .destination_address_i (destination_address),
    .protocol_i            (protocol),
    .segment_length_i      (segment_length),
    .empty_o               (empty),
    .pop_i                 (pop),
    .checksum_o            (checksum)
  );

  internet_checksum_engine_checker u_sum_check (
    .clk_i                 (clk_i),
    .rst_ni                (rst_n),
    .push_i                (push),
    .full_i                (full),
    .data_word_i           (data_word),
    .odd_tail_i            (odd_tail),
    .first_word_i          (first_word),
    .last_word_i           (last_word),
    .with_pseudo_i         (with_pseudo),
    .source_address_i      (source_address),
    .destination_address_i (destination_address),
    .protocol_i            (protocol),
    .segment_length_i      (segment_length),
    .empty_i               (empty),
    .pop_i                 (pop),
    .checksum_i            (checksum),
    .fail_count_o          (fail_count),
    .pending_o             (pending)
  );

  // Result side: pop stalls in random bursts, none near the end
  always @(posedge clk_i) begin
    if (quiet_tail) begin
      pop <= 1'b1;
    end else if (pop_stall != 0) begin
      pop_stall <= pop_stall - 1;
      pop       <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      pop_stall <= $urandom_range(0, 8);
      pop       <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog
  initial begin : watchdog_p
    repeat (CycleLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // One word beat, with an optional idle burst in front of it
  task automatic send_word(input logic [15:0] data, input logic odd, input logic first,
                           input logic last, input logic pseudo, input logic [31:0] src,
                           input logic [31:0] dst, input logic [7:0] proto,
                           input logic [15:0] seglen);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    push                <= 1'b1;
    data_word           <= data;
    odd_tail            <= odd;
    first_word          <= first;
    last_word           <= last;
    with_pseudo         <= pseudo;
    source_address      <= src;
    destination_address <= dst;
    protocol            <= proto;
    segment_length      <= seglen;
    do @(posedge clk_i); while (full);
    words_sent++;
  endtask

  // Hold the input side until every queued checksum has been popped
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Well-formed packet: first word, body, last word with random odd tail
  task automatic send_packet(input int unsigned len);
    logic        pseudo;
    logic        tail_odd;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] seglen;
    logic [15:0] data;
    logic        odd;
    pseudo   = $urandom_range(0, 2) != 0;
    tail_odd = 1'($urandom_range(0, 1));
    src      = $urandom;
    dst      = $urandom;
    case ($urandom_range(0, 2))
      0: proto = 8'd6;
      1: proto = 8'd17;
      default: proto = 8'($urandom);
    endcase
    seglen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(len * 2 - tail_odd);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 15))
        0: data = 16'h0000;
        1: data = 16'hFFFF;
        default: data = 16'($urandom);
      endcase
      odd = (i == len - 1) ? tail_odd : ($urandom_range(0, 15) == 0);
      if (i == 0) begin
        send_word(data, odd, 1'b1, len == 1, pseudo, src, dst, proto, seglen);
      end else begin
        // pseudo flag and header fields on later words must be ignored
        send_word(data, odd, 1'b0, i == len - 1, 1'($urandom_range(0, 1)), $urandom,
                  $urandom, 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin : stimulus_p
    bit pressure_done;
    pressure_done = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // words before any first word build on the reset sum
    send_word(16'h1234, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    send_word(16'h00AB, 1'b0, 1'b0, 1'b1, 1'b1, 32'hFFFFFFFF, 32'h1, 8'hFF, 16'hFFFF);
    // a later word without first continues from the folded sum
    send_word(16'h0101, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    // single-word packets: zero sum and all-ones sum
    send_word(16'h0000, 1'b0, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    send_word(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    // pseudoheader extremes with repeated carries
    send_word(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 16'hFFFF);
    send_word(16'h0000, 1'b0, 1'b1, 1'b0, 1'b1, 32'h0, 32'h0, 8'h00, 16'h0000);
    send_word(16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    // pseudo flag without first word is ignored
    send_word(16'h4500, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    send_word(16'h0073, 1'b0, 1'b0, 1'b0, 1'b1, 32'hA5A5A5A5, 32'h5A5A5A5A, 8'h11, 16'h1234);
    send_word(16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, 32'hFFFF0000, 32'h0000FFFF, 8'h06, 16'hABCD);
    // odd tail on a non-last word, then an odd last word
    send_word(16'hABCD, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    send_word(16'h1234, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    send_word(16'h56FF, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    // TCP-like segment
    send_word(16'h1F90, 1'b0, 1'b1, 1'b0, 1'b1, 32'hC0A80001, 32'hC0A800C7, 8'd6, 16'd7);
    send_word(16'hC350, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    send_word(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    send_word(16'h4100, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 8'h00, 16'h0000);
    // UDP-like segment, one word
    send_word(16'hFEDC, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0A000001, 32'hFFFFFFFF, 8'd17, 16'd2);

    // random packets with some stray words mixed in
    while (words_sent < WordTarget) begin
      if (!quiet_tail && words_sent >= QuietFrom) begin
        quiet_tail <= 1'b1;
      end
      if (!pressure_done && words_sent >= 700) begin
        pressure_done = 1'b1;
        drain_results();
      end
      if ($urandom_range(0, 9) == 0) begin
        send_word(16'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, $urandom,
                  8'($urandom), 16'($urandom));
      end else if ($urandom_range(0, 19) == 0) begin
        send_packet($urandom_range(9, 40));
      end else begin
        send_packet($urandom_range(1, 8));
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ice_pkg.sv
rtl/core/ice_front.sv
rtl/core/ice_back.sv
rtl/core/internet_checksum_engine_top.sv
dv/internet_checksum_engine_checker.sv
dv/internet_checksum_engine_top_tb.sv
